@@ hw/rtl/assert_macros.svh @@
// Assertion helpers for the checker modules. They assume a clk and a rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle, ignored while reset is high.
`define CHK_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("checker: property failed");

// Implication checked in the next cycle, also active during reset.
`define CHK_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("checker: property failed");

`endif

@@ hw/rtl/bstsp_pkg.sv @@
`default_nettype none
package bstsp_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int SIZE_W = 11;
  localparam int ROW_W  = 11;

  localparam logic [1:0] MODE_SHRINK = 2'd0;
  localparam logic [1:0] MODE_THIN   = 2'd1;
  localparam logic [1:0] MODE_SKEL   = 2'd2;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  typedef logic [8:0] pat_t;

  typedef struct packed {
    pat_t val;
    pat_t care;
    pat_t any;
  } uncond_t;

  // Edge flags of a window center: top, bottom, left, right.
  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
  } edge_t;

  typedef struct packed {
    logic              s1v;
    edge_t             e1;
    logic              s2v;
    edge_t             e2;
    logic              last;
    logic [COL_W-1:0]  col;
  } pos_t;

  localparam pat_t COND_TABLE [66] = '{
    9'o120, 9'o420, 9'o024, 9'o021, 9'o030, 9'o220, 9'o060, 9'o022,
    9'o130, 9'o320, 9'o620, 9'o460, 9'o064, 9'o026, 9'o023, 9'o031,
    9'o630, 9'o231, 9'o360, 9'o132, 9'o330, 9'o660, 9'o066, 9'o033,
    9'o631, 9'o364,
    9'o333, 9'o770, 9'o666, 9'o077, 9'o733, 9'o337, 9'o774, 9'o771,
    9'o766, 9'o667, 9'o477, 9'o177, 9'o737, 9'o775, 9'o767, 9'o577,
    9'o131, 9'o720, 9'o464, 9'o027, 9'o730, 9'o331, 9'o760, 9'o664,
    9'o466, 9'o067, 9'o037, 9'o133, 9'o731, 9'o764, 9'o467, 9'o137,
    9'o230, 9'o260, 9'o062, 9'o032,
    9'o773, 9'o776, 9'o677, 9'o377
  };

  localparam uncond_t UNC_COMMON [8] = '{
    '{9'o520, 9'o527, 9'o007}, '{9'o424, 9'o535, 9'o111},
    '{9'o025, 9'o725, 9'o700}, '{9'o121, 9'o565, 9'o444},
    '{9'o234, 9'o376, 9'o000}, '{9'o261, 9'o673, 9'o000},
    '{9'o162, 9'o376, 9'o000}, '{9'o432, 9'o673, 9'o000}
  };

  localparam uncond_t UNC_ST [37] = '{
    '{9'o120, 9'o777, 9'o000}, '{9'o420, 9'o777, 9'o000},
    '{9'o022, 9'o777, 9'o000}, '{9'o030, 9'o777, 9'o000},
    '{9'o130, 9'o777, 9'o000}, '{9'o320, 9'o777, 9'o000},
    '{9'o620, 9'o777, 9'o000}, '{9'o460, 9'o777, 9'o000},
    '{9'o064, 9'o777, 9'o000}, '{9'o026, 9'o777, 9'o000},
    '{9'o023, 9'o777, 9'o000}, '{9'o031, 9'o777, 9'o000},
    '{9'o360, 9'o777, 9'o000}, '{9'o630, 9'o777, 9'o000},
    '{9'o231, 9'o777, 9'o000}, '{9'o132, 9'o777, 9'o000},
    '{9'o334, 9'o777, 9'o000}, '{9'o134, 9'o777, 9'o000},
    '{9'o324, 9'o777, 9'o000},
    '{9'o661, 9'o777, 9'o000}, '{9'o461, 9'o777, 9'o000},
    '{9'o621, 9'o777, 9'o000},
    '{9'o166, 9'o777, 9'o000}, '{9'o164, 9'o777, 9'o000},
    '{9'o126, 9'o777, 9'o000},
    '{9'o433, 9'o777, 9'o000}, '{9'o431, 9'o777, 9'o000},
    '{9'o423, 9'o777, 9'o000},
    '{9'o660, 9'o660, 9'o000},
    '{9'o270, 9'o373, 9'o000}, '{9'o270, 9'o676, 9'o000},
    '{9'o072, 9'o676, 9'o000}, '{9'o072, 9'o373, 9'o000},
    '{9'o262, 9'o277, 9'o000}, '{9'o262, 9'o772, 9'o000},
    '{9'o232, 9'o772, 9'o000}, '{9'o232, 9'o277, 9'o000}
  };

  localparam uncond_t UNC_K [18] = '{
    '{9'o021, 9'o777, 9'o000}, '{9'o024, 9'o777, 9'o000},
    '{9'o120, 9'o777, 9'o000}, '{9'o420, 9'o777, 9'o000},
    '{9'o022, 9'o777, 9'o000}, '{9'o030, 9'o777, 9'o000},
    '{9'o060, 9'o777, 9'o000}, '{9'o220, 9'o777, 9'o000},
    '{9'o230, 9'o777, 9'o000}, '{9'o260, 9'o777, 9'o000},
    '{9'o032, 9'o777, 9'o000}, '{9'o062, 9'o777, 9'o000},
    '{9'o660, 9'o660, 9'o000}, '{9'o033, 9'o033, 9'o000},
    '{9'o270, 9'o270, 9'o000}, '{9'o262, 9'o262, 9'o000},
    '{9'o072, 9'o072, 9'o000}, '{9'o232, 9'o232, 9'o000}
  };

  function automatic pat_t edge_mask(edge_t e);
    pat_t m;
    m = 9'o777;
    if (e.top)    m = m & ~9'o700;
    if (e.bottom) m = m & ~9'o007;
    if (e.left)   m = m & ~9'o444;
    if (e.right)  m = m & ~9'o111;
    return m;
  endfunction

  // Each mode uses a contiguous slice of the conditional table.
  function automatic logic cond_hit(pat_t pat, logic [1:0] mode);
    int   lo;
    int   hi;
    logic hit;
    lo  = 0;
    hi  = -1;
    hit = 1'b0;
    unique case (mode)
      MODE_SHRINK: begin lo = 0;  hi = 57; end
      MODE_THIN:   begin lo = 16; hi = 61; end
      MODE_SKEL:   begin lo = 26; hi = 65; end
      default:     begin lo = 0;  hi = -1; end
    endcase
    for (int i = 0; i < 66; i++) begin
      if (i >= lo && i <= hi && pat == COND_TABLE[i]) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic logic entry_hit(uncond_t e, pat_t pat);
    logic any_ok;
    any_ok = (e.any == 9'o000) || ((pat & e.any) != 9'o000);
    return ((pat & e.care & ~e.any) == e.val) && any_ok;
  endfunction

  function automatic logic uncond_hit(pat_t pat, logic [1:0] mode);
    logic hc;
    logic hst;
    logic hk;
    hc  = 1'b0;
    hst = 1'b0;
    hk  = 1'b0;
    for (int i = 0; i < 8; i++)  if (entry_hit(UNC_COMMON[i], pat)) hc = 1'b1;
    for (int i = 0; i < 37; i++) if (entry_hit(UNC_ST[i], pat)) hst = 1'b1;
    for (int i = 0; i < 18; i++) if (entry_hit(UNC_K[i], pat)) hk = 1'b1;
    unique case (mode)
      MODE_SHRINK, MODE_THIN: return hc | hst;
      MODE_SKEL:              return hc | hk;
      default:                return 1'b0;
    endcase
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/binary_shrink_thin_skeleton_pass_core.sv @@
// The completing beat passes the b, c and d registers, then sets the output register.
// Throughput: one beat per cycle unless output stalls; 3x3 matching is constant compare
// logic and each line store is one read and one write per cycle, so nothing iterates.
// A frame is W*H pixel beats plus 2*W+2 drain beats; the first 2*W+2 beats give no result.
// Reset (rst, synchronous) clears the pipeline, windows, position and registers to
// mode 0 and 372x372; the line stores are not cleared and need no clearing pass.
`default_nettype none
module binary_shrink_thin_skeleton_pass_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [0] pixel_in, [7:1] zero
  input  wire logic        s_axis_tuser,   // [0] flush
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [0] pixel_out, [1] erased, [7:2] zero
  output logic             m_axis_tlast,   // last_pixel
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [10:0] cfg_data
);
  import bstsp_pkg::*;

  logic [1:0]        mode;
  logic [SIZE_W-1:0] width;
  logic [SIZE_W-1:0] height;
  logic [COL_W-1:0]  column_count;
  logic [ROW_W-1:0]  row_count;

  logic [1:0] img_mem  [MAX_WIDTH];
  logic [1:0] mark_mem [MAX_WIDTH];
  logic [1:0] img_rd;
  logic [1:0] mark_rd;

  pat_t image_window;
  pat_t mark_window;

  logic       b_v, c_v, d_v;
  pos_t       b_pos, c_pos, d_pos;
  logic       b_x;
  logic       c_dc, d_dc;
  logic [1:0] c_mrd;

  logic       advance;
  logic       accept;
  pos_t       a_pos;
  logic       a_x;
  logic [ROW_W-1:0] q1row, q2row;
  logic [SIZE_W-1:0] colx;
  pat_t       image_window_next;
  pat_t       mark_window_next;
  logic       c_mark;
  pat_t       pat2;
  logic       keep;

  function automatic logic [SIZE_W-1:0] clamp_size(logic [10:0] v, int hi);
    if (v < 11'd3) return 11'd3;
    if (v > SIZE_W'(hi)) return SIZE_W'(hi);
    return v;
  endfunction

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = advance;
  assign accept        = s_axis_tvalid && advance;
  assign colx          = {1'b0, column_count};

  // Position flags of the two window centers: one row and a pixel back, two rows and two pixels back.
  always_comb begin
    q1row = (column_count != '0) ? row_count - ROW_W'(1) : row_count - ROW_W'(2);
    q2row = (colx >= 11'd2) ? row_count - ROW_W'(2) : row_count - ROW_W'(3);
    a_pos.s1v = ((row_count >= ROW_W'(2)) || (row_count == ROW_W'(1) && column_count != '0))
                && (q1row < height);
    a_pos.e1.top    = (q1row == '0);
    a_pos.e1.bottom = (q1row == height - SIZE_W'(1));
    a_pos.e1.left   = (colx == 11'd1);
    a_pos.e1.right  = (column_count == '0);
    a_pos.s2v = (row_count >= ROW_W'(3)) || (row_count == ROW_W'(2) && colx >= 11'd2);
    a_pos.e2.top    = (q2row == '0);
    a_pos.e2.bottom = (q2row == height - SIZE_W'(1));
    a_pos.e2.left   = (colx == 11'd2);
    a_pos.e2.right  = (colx == 11'd1);
    a_pos.last      = (q2row == height - SIZE_W'(1)) && (colx == 11'd1);
    a_pos.col       = column_count;
    a_x = s_axis_tdata[0] && !s_axis_tuser && (row_count < height);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_SHRINK;
      width        <= 11'd372;
      height       <= 11'd372;
      column_count <= '0;
      row_count    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:   mode <= cfg_data[1:0];
        REG_WIDTH: begin
          width        <= clamp_size(cfg_data, MAX_WIDTH);
          column_count <= '0;
          row_count    <= '0;
        end
        REG_HEIGHT: begin
          height       <= clamp_size(cfg_data, MAX_HEIGHT);
          column_count <= '0;
          row_count    <= '0;
        end
        default: ;
      endcase
    end else if (accept) begin
      // The frame ends on the last drain beat, two rows and two pixels past the image.
      if (row_count == height + ROW_W'(2) && colx == 11'd1) begin
        column_count <= '0;
        row_count    <= '0;
      end else if (colx + 11'd1 >= width) begin
        column_count <= '0;
        row_count    <= row_count + ROW_W'(1);
      end else begin
        column_count <= column_count + COL_W'(1);
      end
    end
  end

  // Line stores hold {row above, two rows above} per column.
  always_ff @(posedge clk) begin
    if (accept) begin
      img_rd  <= img_mem[column_count];
      mark_rd <= mark_mem[column_count];
    end
    if (advance && b_v) img_mem[b_pos.col] <= {b_x, img_rd[1]};
    if (advance && c_v) mark_mem[c_pos.col] <= {c_mark, c_mrd[1]};
  end

  always_comb begin
    image_window_next = ((image_window << 1) & 9'o666) | {2'b00, img_rd[0], 2'b00,
                        img_rd[1], 2'b00, b_x};
    c_mark = c_pos.s1v && image_window[4]
             && cond_hit(image_window & edge_mask(c_pos.e1), mode);
    mark_window_next = ((mark_window << 1) & 9'o666) | {2'b00, c_mrd[0], 2'b00,
                       c_mrd[1], 2'b00, c_mark};
    pat2 = mark_window & edge_mask(d_pos.e2);
    keep = d_dc && (!mark_window[4] || uncond_hit(pat2, mode));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v           <= 1'b0;
      c_v           <= 1'b0;
      d_v           <= 1'b0;
      m_axis_tvalid <= 1'b0;
      image_window  <= '0;
      mark_window   <= '0;
    end else begin
      if (advance) begin
        b_v <= accept;
        c_v <= b_v;
        d_v <= c_v;
        if (b_v) image_window <= image_window_next;
        if (c_v) mark_window  <= mark_window_next;
        m_axis_tvalid <= d_v && d_pos.s2v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      b_pos <= a_pos;
      b_x   <= a_x;
      c_pos <= b_pos;
      c_dc  <= image_window_next[8];
      c_mrd <= mark_rd;
      d_pos <= c_pos;
      d_dc  <= c_dc;
      m_axis_tdata <= {6'b0, d_dc && !keep, keep};
      m_axis_tlast <= d_pos.last;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/bstsp_chk.sv @@
`default_nettype none
`include "assert_macros.svh"
module bstsp_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [7:0]  m_axis_tdata
);
  // A result beat that is not taken stays offered.
  `CHK_NEXT(a_hold, m_axis_tvalid && !m_axis_tready && !rst, m_axis_tvalid)
  // A removed pixel is never also kept.
  `CHK_IMPL(a_erase, m_axis_tvalid, !(m_axis_tdata[0] && m_axis_tdata[1]))
  // No new beat enters while the result register is stalled.
  `CHK_IMPL(a_stall, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
  // Reset empties the output.
  `CHK_NEXT(a_rst, rst, !m_axis_tvalid)
  // Padding bits of the result stay zero.
  `CHK_IMPL(a_pad, m_axis_tvalid, m_axis_tdata[7:2] == 6'b0)
endmodule

bind binary_shrink_thin_skeleton_pass_core bstsp_chk u_bstsp_chk (.*);
`default_nettype wire
